[rtl/core/mtep_pkg.sv]
package mtep_pkg;

    localparam int TrackCountDefault = 16;
    localparam int TrackWidth = 4;
    localparam int QueueDepth = 4;

    localparam logic [7:0] MetaEot = 8'h2f;
    localparam logic [7:0] MetaTempo = 8'h51;
    localparam logic [7:0] StatusSysex = 8'hf0;
    localparam logic [7:0] StatusMeta = 8'hff;

    typedef enum logic [3:0] {
        PH_DELTA     = 4'd0,
        PH_STATUS    = 4'd1,
        PH_DATA1     = 4'd2,
        PH_DATA2     = 4'd3,
        PH_SYX_LEN   = 4'd4,
        PH_SYX_BODY  = 4'd5,
        PH_META_CODE = 4'd6,
        PH_META_LEN  = 4'd7,
        PH_META_BODY = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CHANNEL  = 2'd0,
        KIND_SYX_START = 2'd1,
        KIND_SYX_BODY = 2'd2,
        KIND_META     = 2'd3
    } t_kind;

    typedef struct packed {
        logic [TrackWidth-1:0] track;
        logic [7:0]            data_byte;
        logic                  restart;
    } t_item;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  running_status;
        logic [31:0] varlen;
        logic [31:0] remaining;
        logic [7:0]  meta_code;
        logic [7:0]  held_data;
        logic [31:0] tick_time;
        logic [31:0] tempo;
        logic        active;
    } t_track_state;

    typedef struct packed {
        t_kind       kind;
        logic        end_of_track;
        logic [TrackWidth-1:0] track;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [6:0]  second_data;
        logic [31:0] event_time;
        logic [31:0] value;
        logic        last;
    } t_event;

endpackage

[rtl/core/mtep_front.sv]
module mtep_front #(
    parameter int TRACK_COUNT = mtep_pkg::TrackCountDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [mtep_pkg::TrackWidth-1:0] i_track_index,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_restart,
    output logic                            o_q_valid,
    input  logic                            i_q_pop,
    output mtep_pkg::t_item                 o_q_item
);

    localparam int Qd = mtep_pkg::QueueDepth;
    localparam int Aw = $clog2(Qd);

    mtep_pkg::t_item r_mem [Qd];
    logic [Aw-1:0] r_wp, r_rp;
    logic [Aw:0]   r_cnt;
    logic          w_push, w_in_range;

    // track indices at or beyond the configured count are dropped here
    assign w_in_range = ({{(9-mtep_pkg::TrackWidth){1'b0}}, i_track_index} < 9'(TRACK_COUNT));
    assign o_stall = (r_cnt == (Aw+1)'(Qd));
    assign w_push = i_valid && !o_stall && w_in_range;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{track: i_track_index, data_byte: i_data_byte, restart: i_restart};
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Aw+1)'(w_push) - (Aw+1)'(i_q_pop);
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Aw+1)'(Qd)) else $error("queue count overflow");
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (Aw+1)'(Qd)) |-> o_stall) else $error("full queue not stalling");

endmodule

[rtl/core/mtep_back.sv]
module mtep_back #(
    parameter int TRACK_COUNT = mtep_pkg::TrackCountDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    output logic                            o_q_pop,
    input  mtep_pkg::t_item                 i_q_item,
    output logic                            o_valid,
    input  logic                            i_stall,
    output mtep_pkg::t_event                o_event
);

    localparam int Tw = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;

    mtep_pkg::t_track_state r_st [TRACK_COUNT];
    mtep_pkg::t_track_state w_cur, n_st;
    mtep_pkg::t_event       n_ev, r_ev;
    logic                   n_emit, r_valid;
    logic [Tw-1:0]          w_idx;
    logic [7:0]             b;
    logic [31:0]            w_acc, w_rem;
    logic                   w_done;
    logic [3:0]             w_hi;

    assign o_q_pop = i_q_valid && (!r_valid || !i_stall);
    assign w_idx = Tw'(i_q_item.track);
    assign b = i_q_item.data_byte;
    assign o_valid = r_valid;
    assign o_event = r_ev;

    always_comb begin
        w_cur = r_st[w_idx];
        if (i_q_item.restart) begin
            w_cur = '0;
            w_cur.phase = mtep_pkg::PH_DELTA;
            w_cur.active = 1'b1;
        end
        w_acc = {w_cur.varlen[24:0], 7'b0} + {25'b0, b[6:0]};
        w_done = !b[7];
        w_rem = w_cur.remaining - 32'd1;
        w_hi = w_cur.running_status[7:4];
        n_st = w_cur;
        n_emit = 1'b0;
        n_ev = '0;
        n_ev.track = i_q_item.track;
        n_ev.event_time = w_cur.tick_time;
        if (w_cur.active) begin
            case (w_cur.phase)
                mtep_pkg::PH_STATUS: begin
                    if (b[7]) begin
                        if (b == mtep_pkg::StatusSysex) begin
                            n_st.running_status = '0;
                            n_st.varlen = '0;
                            n_st.phase = mtep_pkg::PH_SYX_LEN;
                        end else if (b > mtep_pkg::StatusSysex) begin
                            n_st.running_status = '0;
                            n_st.phase = mtep_pkg::PH_META_CODE;
                        end else begin
                            n_st.running_status = b;
                            n_st.phase = mtep_pkg::PH_DATA1;
                        end
                    end else if (w_cur.running_status[7]) begin
                        if (w_hi == 4'hc || w_hi == 4'hd) begin
                            n_st.phase = mtep_pkg::PH_DELTA;
                            n_st.varlen = '0;
                            n_emit = 1'b1;
                            n_ev.status_byte = w_cur.running_status;
                            n_ev.first_data = b;
                        end else begin
                            n_st.held_data = b;
                            n_st.phase = mtep_pkg::PH_DATA2;
                        end
                    end else begin
                        n_st.varlen = w_acc;
                        n_st.phase = mtep_pkg::PH_DELTA;
                        if (w_done) begin
                            n_st.tick_time = w_cur.tick_time + w_acc;
                            n_st.varlen = '0;
                            n_st.phase = mtep_pkg::PH_STATUS;
                        end
                    end
                end
                mtep_pkg::PH_DATA1: begin
                    if (w_hi == 4'hc || w_hi == 4'hd) begin
                        n_st.phase = mtep_pkg::PH_DELTA;
                        n_st.varlen = '0;
                        n_emit = 1'b1;
                        n_ev.status_byte = w_cur.running_status;
                        n_ev.first_data = b;
                    end else begin
                        n_st.held_data = b;
                        n_st.phase = mtep_pkg::PH_DATA2;
                    end
                end
                mtep_pkg::PH_DATA2: begin
                    n_st.phase = mtep_pkg::PH_DELTA;
                    n_st.varlen = '0;
                    n_emit = 1'b1;
                    n_ev.status_byte = w_cur.running_status;
                    n_ev.first_data = w_cur.held_data;
                    n_ev.second_data = (w_hi == 4'h8) ? 7'd0 : b[6:0];
                end
                mtep_pkg::PH_SYX_LEN: begin
                    n_st.varlen = w_acc;
                    if (w_done) begin
                        n_st.remaining = w_acc;
                        n_emit = 1'b1;
                        n_ev.kind = mtep_pkg::KIND_SYX_START;
                        n_ev.status_byte = mtep_pkg::StatusSysex;
                        if (w_acc == '0) begin
                            n_st.phase = mtep_pkg::PH_DELTA;
                            n_ev.last = 1'b1;
                        end else begin
                            n_st.phase = mtep_pkg::PH_SYX_BODY;
                            n_ev.value = w_acc;
                        end
                    end
                end
                mtep_pkg::PH_SYX_BODY: begin
                    n_st.remaining = w_rem;
                    n_emit = 1'b1;
                    n_ev.kind = mtep_pkg::KIND_SYX_BODY;
                    n_ev.status_byte = mtep_pkg::StatusSysex;
                    n_ev.first_data = b;
                    n_ev.value = w_cur.varlen;
                    if (w_rem == '0) begin
                        n_st.phase = mtep_pkg::PH_DELTA;
                        n_st.varlen = '0;
                        n_ev.last = 1'b1;
                    end
                end
                mtep_pkg::PH_META_CODE: begin
                    n_st.meta_code = b;
                    n_st.varlen = '0;
                    n_st.phase = mtep_pkg::PH_META_LEN;
                end
                mtep_pkg::PH_META_LEN: begin
                    n_st.varlen = w_acc;
                    if (w_done) begin
                        n_ev.kind = mtep_pkg::KIND_META;
                        n_ev.status_byte = mtep_pkg::StatusMeta;
                        if (w_cur.meta_code == mtep_pkg::MetaEot) begin
                            n_st.active = 1'b0;
                            n_st.phase = mtep_pkg::PH_DELTA;
                            n_st.varlen = '0;
                            n_emit = 1'b1;
                            n_ev.end_of_track = 1'b1;
                            n_ev.first_data = mtep_pkg::MetaEot;
                        end else begin
                            if (w_cur.meta_code == mtep_pkg::MetaTempo) n_st.tempo = '0;
                            if (w_acc == '0) begin
                                n_st.phase = mtep_pkg::PH_DELTA;
                                n_emit = (w_cur.meta_code == mtep_pkg::MetaTempo);
                                n_ev.first_data = mtep_pkg::MetaTempo;
                            end else begin
                                n_st.remaining = w_acc;
                                n_st.phase = mtep_pkg::PH_META_BODY;
                            end
                        end
                    end
                end
                mtep_pkg::PH_META_BODY: begin
                    if (w_cur.meta_code == mtep_pkg::MetaTempo) begin
                        n_st.tempo = {w_cur.tempo[23:0], b};
                    end
                    n_st.remaining = w_rem;
                    if (w_rem == '0) begin
                        n_st.phase = mtep_pkg::PH_DELTA;
                        n_st.varlen = '0;
                        n_emit = (w_cur.meta_code == mtep_pkg::MetaTempo);
                        n_ev.kind = mtep_pkg::KIND_META;
                        n_ev.status_byte = mtep_pkg::StatusMeta;
                        n_ev.first_data = mtep_pkg::MetaTempo;
                        n_ev.value = n_st.tempo;
                    end
                end
                default: begin
                    n_st.varlen = w_acc;
                    n_st.phase = mtep_pkg::PH_DELTA;
                    if (w_done) begin
                        n_st.tick_time = w_cur.tick_time + w_acc;
                        n_st.varlen = '0;
                        n_st.phase = mtep_pkg::PH_STATUS;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TRACK_COUNT; i++) begin
                r_st[i] <= '{phase: mtep_pkg::PH_DELTA, active: 1'b1, default: '0};
            end
            r_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_st[w_idx] <= n_st;
                r_valid <= n_emit;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (o_q_pop && n_emit) r_ev <= n_ev;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_ev))) else $error("result lost");
    a_no_pop_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |-> !o_q_pop) else $error("pop while blocked");
    a_eot_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_ev.end_of_track) |-> (r_ev.kind == mtep_pkg::KIND_META))
        else $error("end of track with wrong kind");

endmodule

[rtl/core/midi_track_event_parser_core.sv]
// Standard MIDI File track parser: one byte of one track per transaction, one per cycle
// sustained while neither side stalls. A four-entry queue sits between the input and the
// per-track state machine, and results wait in an output register, so either side may
// stall. Bytes of tracks at or beyond TRACK_COUNT are accepted and dropped. The state
// update of one track per cycle sets the rate.
module midi_track_event_parser_core #(
    parameter int TRACK_COUNT = mtep_pkg::TrackCountDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_track_index,
    input  logic [7:0]  i_data_byte,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic        o_end_of_track,
    output logic [3:0]  o_track_out,
    output logic [7:0]  o_status_byte,
    output logic [7:0]  o_first_data,
    output logic [6:0]  o_second_data,
    output logic [31:0] o_event_time,
    output logic [31:0] o_value,
    output logic        o_last
);

    logic             w_q_valid, w_q_pop;
    mtep_pkg::t_item  w_q_item;
    mtep_pkg::t_event w_ev;

    mtep_front #(.TRACK_COUNT(TRACK_COUNT)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_track_index, .i_data_byte, .i_restart,
        .o_q_valid(w_q_valid), .i_q_pop(w_q_pop), .o_q_item(w_q_item)
    );

    mtep_back #(.TRACK_COUNT(TRACK_COUNT)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_q_valid), .o_q_pop(w_q_pop), .i_q_item(w_q_item),
        .o_valid, .i_stall, .o_event(w_ev)
    );

    assign o_kind = w_ev.kind;
    assign o_end_of_track = w_ev.end_of_track;
    assign o_track_out = w_ev.track;
    assign o_status_byte = w_ev.status_byte;
    assign o_first_data = w_ev.first_data;
    assign o_second_data = w_ev.second_data;
    assign o_event_time = w_ev.event_time;
    assign o_value = w_ev.value;
    assign o_last = w_ev.last;

endmodule

[tb/sv/midi_track_event_parser_core_tb.sv]
module midi_track_event_parser_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumTracks = 16;
    localparam int NumRandom = 1200;
    localparam int CycleLimit = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_track_index;
    logic [7:0]  i_data_byte;
    logic        i_restart;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic        o_end_of_track;
    logic [3:0]  o_track_out;
    logic [7:0]  o_status_byte;
    logic [7:0]  o_first_data;
    logic [6:0]  o_second_data;
    logic [31:0] o_event_time;
    logic [31:0] o_value;
    logic        o_last;

    midi_track_event_parser_core dut (.*);

    typedef struct {
        logic [3:0]       trk;
        logic [7:0]       byte_in;
        logic             rst;
        logic             has_ev;
        mtep_pkg::t_event ev;
    } t_row;

    mtep_pkg::t_track_state trk_state [NumTracks];
    mtep_pkg::t_event       pending_events [$];
    mtep_pkg::t_item        byte_stream [$];
    t_row                   directed_rows [$];
    int                     error_count;
    int                     cycle_count;
    bit                     sending_done;
    bit                     hold_off;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic mtep_pkg::t_event make_ev(mtep_pkg::t_kind k, logic eot, logic [3:0] t,
                                                 logic [7:0] st, logic [7:0] d1,
                                                 logic [6:0] d2, logic [31:0] tm,
                                                 logic [31:0] val, logic lst);
        mtep_pkg::t_event e;
        e.kind = k; e.end_of_track = eot; e.track = t; e.status_byte = st;
        e.first_data = d1; e.second_data = d2; e.event_time = tm; e.value = val;
        e.last = lst;
        return e;
    endfunction

    function automatic void clear_track(int t);
        trk_state[t] = '0;
        trk_state[t].phase = mtep_pkg::PH_DELTA;
        trk_state[t].active = 1'b1;
    endfunction

    function automatic bit varlen_add(int t, logic [7:0] b);
        trk_state[t].varlen = (trk_state[t].varlen << 7) + 32'(b[6:0]);
        return !b[7];
    endfunction

    function automatic void to_delta(int t);
        trk_state[t].phase = mtep_pkg::PH_DELTA;
        trk_state[t].varlen = '0;
    endfunction

    function automatic bit delta_byte(int t, logic [7:0] b);
        trk_state[t].phase = mtep_pkg::PH_DELTA;
        if (varlen_add(t, b)) begin
            trk_state[t].tick_time += trk_state[t].varlen;
            trk_state[t].varlen = '0;
            trk_state[t].phase = mtep_pkg::PH_STATUS;
        end
        return 1'b0;
    endfunction

    function automatic bit first_data_byte(int t, logic [7:0] b, output mtep_pkg::t_event e);
        logic [7:0] st;
        st = trk_state[t].running_status;
        if (st[7:4] == 4'hc || st[7:4] == 4'hd) begin
            to_delta(t);
            e = make_ev(mtep_pkg::KIND_CHANNEL, 0, 4'(t), st, b, 0,
                        trk_state[t].tick_time, 0, 0);
            return 1'b1;
        end
        trk_state[t].held_data = b;
        trk_state[t].phase = mtep_pkg::PH_DATA2;
        return 1'b0;
    endfunction

    function automatic bit parse_byte(logic [3:0] t, logic [7:0] b, logic rst,
                                      output mtep_pkg::t_event e);
        logic [31:0] len;
        logic [7:0]  st;
        logic [6:0]  d2;
        e = '0;
        if (rst) clear_track(t);
        if (!trk_state[t].active) return 1'b0;
        case (trk_state[t].phase)
            mtep_pkg::PH_STATUS: begin
                if (b[7]) begin
                    if (b == mtep_pkg::StatusSysex) begin
                        trk_state[t].running_status = '0;
                        trk_state[t].varlen = '0;
                        trk_state[t].phase = mtep_pkg::PH_SYX_LEN;
                    end else if (b > mtep_pkg::StatusSysex) begin
                        trk_state[t].running_status = '0;
                        trk_state[t].phase = mtep_pkg::PH_META_CODE;
                    end else begin
                        trk_state[t].running_status = b;
                        trk_state[t].phase = mtep_pkg::PH_DATA1;
                    end
                    return 1'b0;
                end
                if (trk_state[t].running_status[7]) return first_data_byte(t, b, e);
                return delta_byte(t, b);
            end
            mtep_pkg::PH_DATA1: return first_data_byte(t, b, e);
            mtep_pkg::PH_DATA2: begin
                st = trk_state[t].running_status;
                d2 = (st[7:4] == 4'h8) ? 7'd0 : b[6:0];
                to_delta(t);
                e = make_ev(mtep_pkg::KIND_CHANNEL, 0, t, st, trk_state[t].held_data, d2,
                            trk_state[t].tick_time, 0, 0);
                return 1'b1;
            end
            mtep_pkg::PH_SYX_LEN: begin
                if (!varlen_add(t, b)) return 1'b0;
                len = trk_state[t].varlen;
                trk_state[t].remaining = len;
                if (len == 0) begin
                    to_delta(t);
                    e = make_ev(mtep_pkg::KIND_SYX_START, 0, t, mtep_pkg::StatusSysex, 0, 0,
                                trk_state[t].tick_time, 0, 1);
                    return 1'b1;
                end
                trk_state[t].phase = mtep_pkg::PH_SYX_BODY;
                e = make_ev(mtep_pkg::KIND_SYX_START, 0, t, mtep_pkg::StatusSysex, 0, 0,
                            trk_state[t].tick_time, len, 0);
                return 1'b1;
            end
            mtep_pkg::PH_SYX_BODY: begin
                len = trk_state[t].varlen;
                trk_state[t].remaining -= 1;
                e = make_ev(mtep_pkg::KIND_SYX_BODY, 0, t, mtep_pkg::StatusSysex, b, 0,
                            trk_state[t].tick_time, len, trk_state[t].remaining == 0);
                if (trk_state[t].remaining == 0) to_delta(t);
                return 1'b1;
            end
            mtep_pkg::PH_META_CODE: begin
                trk_state[t].meta_code = b;
                trk_state[t].varlen = '0;
                trk_state[t].phase = mtep_pkg::PH_META_LEN;
                return 1'b0;
            end
            mtep_pkg::PH_META_LEN: begin
                if (!varlen_add(t, b)) return 1'b0;
                len = trk_state[t].varlen;
                if (trk_state[t].meta_code == mtep_pkg::MetaEot) begin
                    trk_state[t].active = 1'b0;
                    to_delta(t);
                    e = make_ev(mtep_pkg::KIND_META, 1, t, mtep_pkg::StatusMeta,
                                mtep_pkg::MetaEot, 0, trk_state[t].tick_time, 0, 0);
                    return 1'b1;
                end
                if (trk_state[t].meta_code == mtep_pkg::MetaTempo) trk_state[t].tempo = '0;
                if (len == 0) begin
                    to_delta(t);
                    if (trk_state[t].meta_code == mtep_pkg::MetaTempo) begin
                        e = make_ev(mtep_pkg::KIND_META, 0, t, mtep_pkg::StatusMeta,
                                    mtep_pkg::MetaTempo, 0, trk_state[t].tick_time, 0, 0);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                trk_state[t].remaining = len;
                trk_state[t].phase = mtep_pkg::PH_META_BODY;
                return 1'b0;
            end
            mtep_pkg::PH_META_BODY: begin
                if (trk_state[t].meta_code == mtep_pkg::MetaTempo)
                    trk_state[t].tempo = (trk_state[t].tempo << 8) + 32'(b);
                trk_state[t].remaining -= 1;
                if (trk_state[t].remaining != 0) return 1'b0;
                to_delta(t);
                if (trk_state[t].meta_code == mtep_pkg::MetaTempo) begin
                    e = make_ev(mtep_pkg::KIND_META, 0, t, mtep_pkg::StatusMeta,
                                mtep_pkg::MetaTempo, 0, trk_state[t].tick_time,
                                trk_state[t].tempo, 0);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return delta_byte(t, b);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    function automatic mtep_pkg::t_item mk(logic [3:0] t, logic [7:0] b, logic r = 1'b0);
        mtep_pkg::t_item it;
        it.track = t; it.data_byte = b; it.restart = r;
        return it;
    endfunction

    task automatic add_row(logic [3:0] t, logic [7:0] b, logic r, logic h,
                           mtep_pkg::t_event e);
        t_row row;
        row.trk = t; row.byte_in = b; row.rst = r; row.has_ev = h; row.ev = e;
        directed_rows.push_back(row);
    endtask

    task automatic build_directed();
        mtep_pkg::t_event z;
        z = '0;
        // note on at time 0 after reset, then note off
        add_row(0, 8'h00, 0, 0, z);
        add_row(0, 8'h90, 0, 0, z);
        add_row(0, 8'h3c, 0, 0, z);
        add_row(0, 8'h7f, 0, 1, make_ev(mtep_pkg::KIND_CHANNEL, 0, 0, 8'h90, 8'h3c, 7'h7f,
                                        0, 0, 0));
        add_row(0, 8'h00, 0, 0, z);
        add_row(0, 8'h80, 0, 0, z);
        add_row(0, 8'hff, 0, 0, z);
        add_row(0, 8'hff, 0, 1, make_ev(mtep_pkg::KIND_CHANNEL, 0, 0, 8'h80, 8'hff, 7'h00,
                                        0, 0, 0));
        // two-byte message and two-byte delta on another track
        add_row(15, 8'hff, 0, 0, z);
        add_row(15, 8'h7f, 0, 0, z);
        add_row(15, 8'hcf, 0, 0, z);
        add_row(15, 8'h80, 0, 1, make_ev(mtep_pkg::KIND_CHANNEL, 0, 15, 8'hcf, 8'h80, 7'h00,
                                         32'h3fff, 0, 0));
        // zero-length sysex
        add_row(3, 8'h00, 1, 0, z);
        add_row(3, mtep_pkg::StatusSysex, 0, 0, z);
        add_row(3, 8'h00, 0, 1, make_ev(mtep_pkg::KIND_SYX_START, 0, 3, mtep_pkg::StatusSysex,
                                        0, 0, 0, 0, 1));
        // zero-length tempo then end of track, then ignored byte
        add_row(3, 8'h00, 0, 0, z);
        add_row(3, mtep_pkg::StatusMeta, 0, 0, z);
        add_row(3, mtep_pkg::MetaTempo, 0, 0, z);
        add_row(3, 8'h00, 0, 1, make_ev(mtep_pkg::KIND_META, 0, 3, mtep_pkg::StatusMeta,
                                        mtep_pkg::MetaTempo, 0, 0, 0, 0));
        add_row(3, 8'h00, 0, 0, z);
        add_row(3, mtep_pkg::StatusMeta, 0, 0, z);
        add_row(3, mtep_pkg::MetaEot, 0, 0, z);
        add_row(3, 8'h00, 0, 1, make_ev(mtep_pkg::KIND_META, 1, 3, mtep_pkg::StatusMeta,
                                        mtep_pkg::MetaEot, 0, 0, 0, 0));
        add_row(3, 8'h90, 0, 0, z);
        add_row(3, 8'h00, 1, 0, z);
    endtask

    function automatic void push_varlen(logic [3:0] t, int unsigned v);
        int n;
        logic [7:0] grp [5];
        n = 0;
        do begin
            grp[n] = 8'(v & 32'h7f);
            v = v >> 7;
            n++;
        end while (v != 0 && n < 5);
        for (int i = n - 1; i >= 0; i--)
            byte_stream.push_back(mk(t, grp[i] | ((i != 0) ? 8'h80 : 8'h00)));
    endfunction

    function automatic void push_event(logic [3:0] t);
        int sel;
        int unsigned len;
        logic [7:0] st;
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) push_varlen(t, $urandom);
        else push_varlen(t, $urandom_range(0, 300));
        if (sel < 45) begin
            st = 8'(8'h80 + $urandom_range(0, 8'h6f));
            if ($urandom_range(0, 2) != 0) byte_stream.push_back(mk(t, st));
            byte_stream.push_back(mk(t, 8'($urandom)));
            byte_stream.push_back(mk(t, 8'($urandom)));
        end else if (sel < 60) begin
            byte_stream.push_back(mk(t, mtep_pkg::StatusSysex));
            len = $urandom_range(0, 6);
            push_varlen(t, len);
            for (int i = 0; i < len; i++) byte_stream.push_back(mk(t, 8'($urandom)));
        end else if (sel < 75) begin
            byte_stream.push_back(mk(t, 8'(8'hf1 + $urandom_range(0, 14))));
            byte_stream.push_back(mk(t, mtep_pkg::MetaTempo));
            len = $urandom_range(0, 5);
            push_varlen(t, len);
            for (int i = 0; i < len; i++) byte_stream.push_back(mk(t, 8'($urandom)));
        end else if (sel < 85) begin
            byte_stream.push_back(mk(t, mtep_pkg::StatusMeta));
            byte_stream.push_back(mk(t, 8'($urandom_range(0, 127))));
            len = $urandom_range(0, 4);
            push_varlen(t, len);
            for (int i = 0; i < len; i++) byte_stream.push_back(mk(t, 8'($urandom)));
        end else if (sel < 90) begin
            byte_stream.push_back(mk(t, mtep_pkg::StatusMeta));
            byte_stream.push_back(mk(t, mtep_pkg::MetaEot));
            byte_stream.push_back(mk(t, 8'h00));
            byte_stream.push_back(mk(t, 8'($urandom), 1'b1));
        end else begin
            byte_stream.push_back(mk(t, 8'($urandom), 1'($urandom_range(0, 4) == 0)));
        end
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_item(mtep_pkg::t_item it, bit checked_row, t_row row);
        mtep_pkg::t_event e;
        bit got;
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            wait_cycles(gap);
        end
        i_valid <= 1'b1;
        i_track_index <= it.track;
        i_data_byte <= it.data_byte;
        i_restart <= it.restart;
        do @(posedge i_clk); while (o_stall);
        got = parse_byte(it.track, it.data_byte, it.restart, e);
        if (checked_row) begin
            if (got != row.has_ev)
                report_mismatch("directed count", 32'(got), 32'(row.has_ev));
            else if (got && row.ev != e)
                report_mismatch("directed event", 32'(e.first_data), 32'(row.ev.first_data));
        end
        if (got) pending_events.push_back(e);
    endtask

    initial begin
        t_row            dummy;
        mtep_pkg::t_item it;
        logic [3:0]      tsel;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_track_index = '0;
        i_data_byte = '0;
        i_restart = 1'b0;
        error_count = 0;
        sending_done = 1'b0;
        dummy = '{default: '0};
        for (int t = 0; t < NumTracks; t++) clear_track(t);
        build_directed();
        wait_cycles(3);
        i_rst_n <= 1'b1;
        wait_cycles(1);
        foreach (directed_rows[i])
            send_item(mk(directed_rows[i].trk, directed_rows[i].byte_in, directed_rows[i].rst),
                      1'b1, directed_rows[i]);
        for (int n = 0; n < NumRandom; n++) begin
            if (byte_stream.size() == 0) begin
                tsel = 4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                    : $urandom_range(0, 2));
                push_event(tsel);
            end
            it = byte_stream.pop_front();
            send_item(it, 1'b0, dummy);
        end
        i_valid <= 1'b0;
        sending_done = 1'b1;
    end

    initial begin
        hold_off = 1'b0;
        wait (i_rst_n);
        wait_cycles(200);
        hold_off = 1'b1;
        wait_cycles(150);
        hold_off = 1'b0;
    end

    initial begin
        int gap;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
            end else if (o_valid && !i_stall) begin
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
                if (gap > 0) begin
                    i_stall <= 1'b1;
                    wait_cycles(gap - 1);
                    @(posedge i_clk);
                end
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        mtep_pkg::t_event want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected event", 32'(o_first_data), 32'd0);
            end else begin
                want = pending_events.pop_front();
                if (o_kind != want.kind)
                    report_mismatch("kind", 32'(o_kind), 32'(want.kind));
                if (o_end_of_track != want.end_of_track)
                    report_mismatch("end_of_track", 32'(o_end_of_track),
                                    32'(want.end_of_track));
                if (o_track_out != want.track)
                    report_mismatch("track", 32'(o_track_out), 32'(want.track));
                if (o_status_byte != want.status_byte)
                    report_mismatch("status", 32'(o_status_byte), 32'(want.status_byte));
                if (o_first_data != want.first_data)
                    report_mismatch("first_data", 32'(o_first_data), 32'(want.first_data));
                if (o_second_data != want.second_data)
                    report_mismatch("second_data", 32'(o_second_data), 32'(want.second_data));
                if (o_event_time != want.event_time)
                    report_mismatch("event_time", o_event_time, want.event_time);
                if (o_value != want.value) report_mismatch("value", o_value, want.value);
                if (o_last != want.last) report_mismatch("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    initial begin
        cycle_count = 0;
        fork
            forever begin
                @(posedge i_clk);
                cycle_count++;
            end
            begin
                wait (sending_done && pending_events.size() == 0);
                wait_cycles(20);
            end
            wait (cycle_count >= CycleLimit);
        join_any
        if (cycle_count >= CycleLimit || pending_events.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
